[src/bba_pkg.sv]
`timescale 1ns / 1ps
package bba_pkg;

    localparam int MAP_BYTES_DEF  = 128;
    localparam int ACTIVE_RESET   = 8;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic REG_ACTIVE = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_ONE  = 2'd0,
        MODE_PAIR = 2'd1,
        MODE_BIG  = 2'd2,
        MODE_FREE = 2'd3
    } mode_t;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    scan;
        logic    mark;
        logic    res_set;
        status_t res_code;
        logic    publish;
    } bba_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic is_free;
        logic hit;
        logic scan_end;
        logic mark_last;
        logic out_busy;
    } bba_stat_t;

    typedef struct packed {
        logic       found;
        logic [3:0] pos;
    } run_hit_t;

    function automatic logic [2:0] lowest_zero(input logic [7:0] b);
        logic [2:0] pos;
        pos = '0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!b[k])
            begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

    // n in 0..8
    function automatic logic [7:0] low_mask8(input logic [3:0] n);
        logic [7:0] m;
        m = '0;
        for (int k = 0; k < 8; k++)
        begin
            m[k] = (4'(k) < n);
        end
        return m;
    endfunction

    // lowest start of n free bits in a 16-bit window
    function automatic run_hit_t find_run(input logic [15:0] win, input logic [3:0] n);
        run_hit_t    r;
        logic [15:0] want;
        logic [15:0] free_bits;
        r         = '0;
        want      = {8'h00, low_mask8(n)};
        free_bits = ~win;
        for (int p = 15; p >= 0; p--)
        begin
            if ((5'(p) + 5'(n) <= 5'd16) && (((free_bits >> p) & want) == want))
            begin
                r.found = 1'b1;
                r.pos   = 4'(p);
            end
        end
        return r;
    endfunction

endpackage

[src/bba_ram.sv]
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/bba_ctrl.sv]
`timescale 1ns / 1ps
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd
);

    import bba_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MARK  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.res_code = ST_OK;
        state_next   = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.bad)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_BAD;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    if (stat.is_free)
                    begin
                        cmd.res_set = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
                else if (stat.scan_end)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOSPACE;
                    state_next   = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (stat.mark_last)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[src/bba_datapath.sv]
`timescale 1ns / 1ps
module bba_datapath #(
    parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bba_pkg::bba_cmd_t  cmd,
    output bba_pkg::bba_stat_t stat,
    input  logic [7:0]         active_map_bytes,
    input  logic               kind,
    input  logic [10:0]        block_count,
    input  logic [9:0]         first_block,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [9:0]         block_index,
    output logic [1:0]         status
);

    import bba_pkg::*;

    localparam int AW    = $clog2(MAP_BYTES);
    localparam int EW    = $clog2(MAP_BYTES + 1);
    localparam int BLK_W = AW + 3;
    localparam int IDX_W = (BLK_W > 10) ? BLK_W : 10;
    localparam int SUM_W = (EW + 3 > 12) ? EW + 3 : 12;

    // request
    mode_t          mode_reg;
    logic [10:0]    count_reg;
    logic [2:0]     first_lo_reg;
    logic [2:0]     last_lo_reg;
    logic [AW-1:0]  fb_reg;
    logic [AW-1:0]  lb_reg;
    logic           bad_reg;

    // scan pipeline
    logic [EW-1:0]  rd_addr_reg;
    logic [EW-1:0]  lim_reg;
    logic           data_vld_reg;
    logic [AW-1:0]  data_addr_reg;
    logic [7:0]     prev_reg;
    logic           prev_vld_reg;
    logic [EW-1:0]  run_reg;

    // marking
    logic [AW-1:0]  wr_addr_reg;
    logic [7:0]     wr_lo_reg;
    logic [7:0]     wr_hi_reg;
    logic           wr_step_reg;
    logic [10:0]    rem_reg;
    logic [IDX_W-1:0] idx_reg;

    // clearing pass
    logic [AW-1:0]  clr_addr_reg;

    // result
    status_t        res_code_reg;
    logic           out_valid_reg;
    logic [9:0]     out_index_reg;
    status_t        out_status_reg;

    // memory
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     rdata;

    bba_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    // request decode
    logic [EW-1:0]    eff;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] last_blk;
    logic [SUM_W-1:0] first_byte_w;
    logic [SUM_W-1:0] last_byte_w;
    logic [AW-1:0]    lb_in;
    mode_t            mode_in;

    always_comb
    begin
        eff = (32'(active_map_bytes) > 32'(MAP_BYTES)) ? EW'(MAP_BYTES) : EW'(active_map_bytes);
        sum          = SUM_W'(first_block) + SUM_W'(block_count);
        last_blk     = sum - SUM_W'(1);
        first_byte_w = SUM_W'(first_block) >> 3;
        last_byte_w  = last_blk >> 3;
        lb_in        = last_byte_w[AW-1:0];
        if (kind)
        begin
            mode_in = MODE_FREE;
        end
        else if (block_count == 11'd1)
        begin
            mode_in = MODE_ONE;
        end
        else if (block_count <= 11'd8)
        begin
            mode_in = MODE_PAIR;
        end
        else
        begin
            mode_in = MODE_BIG;
        end
    end

    // scan evaluation
    logic             issue;
    logic [2:0]       zero_pos;
    logic             one_hit;
    logic [15:0]      window;
    run_hit_t         run_res;
    logic [15:0]      pair_mask;
    logic [15:0]      pair_new;
    logic             pair_hit;
    logic [AW-1:0]    pair_addr;
    logic [EW-1:0]    run_next;
    logic             big_hit;
    logic [EW-1:0]    big_start_e;
    logic [AW-1:0]    big_start;
    logic             free_last;
    logic [2:0]       fr_lo;
    logic [2:0]       fr_hi;
    logic [7:0]       fr_mask;
    logic             hit;
    logic [7:0]       big_mask;

    always_comb
    begin
        issue     = rd_addr_reg < lim_reg;
        zero_pos  = lowest_zero(rdata);
        one_hit   = data_vld_reg && (rdata != 8'hFF);
        window    = {rdata, prev_reg};
        run_res   = find_run(window, count_reg[3:0]);
        pair_mask = 16'(low_mask8(count_reg[3:0])) << run_res.pos;
        pair_new  = window | pair_mask;
        pair_hit  = data_vld_reg && prev_vld_reg && run_res.found;
        pair_addr = data_addr_reg - AW'(1);
        run_next  = (rdata == 8'h00) ? run_reg + EW'(1) : '0;
        big_hit   = data_vld_reg && (rdata == 8'h00)
                    && ((32'(run_next) << 3) >= 32'(count_reg));
        big_start_e = EW'(data_addr_reg) + EW'(1) - run_next;
        big_start   = big_start_e[AW-1:0];
        free_last = data_vld_reg && ((EW'(data_addr_reg) + EW'(1)) == lim_reg);
        fr_lo     = (data_addr_reg == fb_reg) ? first_lo_reg : 3'd0;
        fr_hi     = (data_addr_reg == lb_reg) ? last_lo_reg : 3'd7;
        for (int k = 0; k < 8; k++)
        begin
            fr_mask[k] = (3'(k) >= fr_lo) && (3'(k) <= fr_hi);
        end
        case (mode_reg)
            MODE_ONE:  hit = one_hit;
            MODE_PAIR: hit = pair_hit;
            MODE_BIG:  hit = big_hit;
            MODE_FREE: hit = free_last;
            default:   hit = 1'b0;
        endcase
        big_mask = (rem_reg >= 11'd8) ? 8'hFF : low_mask8(rem_reg[3:0]);
    end

    // memory write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = 8'h00;
        if (cmd.clr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.mark)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = (mode_reg == MODE_BIG) ? big_mask : wr_lo_reg;
        end
        else if (cmd.scan && (mode_reg == MODE_FREE) && data_vld_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = data_addr_reg;
            ram_wdata = rdata & ~fr_mask;
        end
    end

    // status to controller
    always_comb
    begin
        stat.clr_last = (clr_addr_reg == AW'(MAP_BYTES - 1));
        stat.bad      = bad_reg;
        stat.is_free  = (mode_reg == MODE_FREE);
        stat.hit      = hit;
        stat.scan_end = !issue && !data_vld_reg;
        case (mode_reg)
            MODE_ONE:  stat.mark_last = 1'b1;
            MODE_PAIR: stat.mark_last = wr_step_reg;
            MODE_BIG:  stat.mark_last = (rem_reg <= 11'd8);
            default:   stat.mark_last = 1'b1;
        endcase
        stat.out_busy = out_valid_reg && !out_ready;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            data_vld_reg  <= 1'b0;
            prev_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                data_vld_reg <= 1'b0;
                prev_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                data_vld_reg <= issue;
                if (data_vld_reg)
                begin
                    prev_vld_reg <= 1'b1;
                end
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= mode_in;
            count_reg    <= block_count;
            first_lo_reg <= first_block[2:0];
            last_lo_reg  <= last_blk[2:0];
            fb_reg       <= first_byte_w[AW-1:0];
            lb_reg       <= lb_in;
            bad_reg      <= (block_count == 11'd0)
                            || (kind && (sum > (SUM_W'(eff) << 3)));
            rd_addr_reg  <= kind ? EW'(first_byte_w[AW-1:0]) : '0;
            lim_reg      <= kind ? EW'(lb_in) + EW'(1) : eff;
            run_reg      <= '0;
        end
        else if (cmd.scan)
        begin
            if (issue)
            begin
                rd_addr_reg <= rd_addr_reg + EW'(1);
            end
            data_addr_reg <= rd_addr_reg[AW-1:0];
            if (data_vld_reg)
            begin
                prev_reg <= rdata;
                run_reg  <= run_next;
            end
            if (hit)
            begin
                wr_step_reg <= 1'b0;
                rem_reg     <= count_reg;
                case (mode_reg)
                    MODE_ONE:
                    begin
                        wr_addr_reg <= data_addr_reg;
                        wr_lo_reg   <= rdata | (8'h01 << zero_pos);
                        idx_reg     <= IDX_W'({data_addr_reg, zero_pos});
                    end
                    MODE_PAIR:
                    begin
                        wr_addr_reg <= pair_addr;
                        wr_lo_reg   <= pair_new[7:0];
                        wr_hi_reg   <= pair_new[15:8];
                        idx_reg     <= IDX_W'({pair_addr, 3'b000}) + IDX_W'(run_res.pos);
                    end
                    MODE_BIG:
                    begin
                        wr_addr_reg <= big_start;
                        idx_reg     <= IDX_W'({big_start, 3'b000});
                    end
                    default:
                    begin
                        idx_reg <= '0;
                    end
                endcase
            end
        end
        else if (cmd.mark)
        begin
            wr_addr_reg <= wr_addr_reg + AW'(1);
            wr_lo_reg   <= wr_hi_reg;
            wr_step_reg <= 1'b1;
            rem_reg     <= rem_reg - 11'd8;
        end
        if (cmd.res_set)
        begin
            res_code_reg <= cmd.res_code;
        end
        if (cmd.publish)
        begin
            out_status_reg <= res_code_reg;
            out_index_reg  <= ((res_code_reg == ST_OK) && (mode_reg != MODE_FREE))
                              ? idx_reg[9:0] : 10'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_index = out_index_reg;
    assign status      = out_status_reg;

endmodule

[src/bitmap_block_allocator_top.sv]
`timescale 1ns / 1ps
// First-fit block allocator over a used-block bitmap held in a byte-wide RAM.
// Request items enter on in_valid/in_ready (kind, block_count, first_block);
// one result item per request leaves on out_valid/out_ready (block_index,
// status). One request is worked on at a time; in_ready is high only when
// the sequencer is idle.
// A bad request skips the scan and the marking. For other requests the byte
// scan reads one bitmap byte per cycle, followed by the marking writes:
// one for a single block, two for 2 to 8 blocks, ceil(count/8) for larger
// runs. A free reads and rewrites each touched byte during the scan.
// in_ready rises together with out_valid.
// active_map_bytes sits on the APB port at address 0 (reset 8); write it
// only while no request is in flight.
// After reset a clearing pass writes zero to every bitmap byte, during
// which in_ready stays low; APB writes are taken throughout.
// A result waiting on a stalled receiver is held in the output register; the
// next request is accepted meanwhile and its result waits until the slot
// frees.
module bitmap_block_allocator_top #(
    parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]  paddr,
    input  logic [bba_pkg::PDATA_W-1:0]  pwdata,
    output logic [bba_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [10:0]                  block_count,
    input  logic [9:0]                   first_block,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [9:0]                   block_index,
    output logic [1:0]                   status
);

    import bba_pkg::*;

    logic [7:0] active_reg;
    logic       reg_sel;
    bba_cmd_t   cmd;
    bba_stat_t  stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_ACTIVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 8'(ACTIVE_RESET);
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            active_reg <= pwdata[7:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(active_reg) : '0;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .active_map_bytes (active_reg),
        .kind             (kind),
        .block_count      (block_count),
        .first_block      (first_block),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .block_index      (block_index),
        .status           (status)
    );

endmodule

[src/bba_checker.sv]
`timescale 1ns / 1ps
module bba_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [9:0] block_index,
    input logic [1:0] status
);

    import bba_pkg::*;

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high straight after an accepted item");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (block_index == 10'd0))
        else $error("non-zero block_index on a failed request");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the block was idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(block_index) && $stable(status)))
        else $error("stalled result item changed");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_index (block_index),
    .status      (status)
);
